### sv/clx_pkg.sv
// shared types, token codes and name tables for the c-subset lexer
package clx_pkg;

  localparam int NAME_BUF_DEPTH_DEF = 8;
  localparam int QUEUE_DEPTH = 4;

  // scanner modes
  typedef enum logic [3:0] {
    M_IDLE, M_PLUS, M_EQ, M_BANG, M_LT, M_GT, M_NUMBER, M_IDENT, M_HASH,
    M_DIRECTIVE, M_INCL, M_PATH, M_CHAR, M_CHAR_ESC, M_STRING
  } mode_t;

  // record types
  localparam logic [1:0] R_LEXEME = 2'd0;
  localparam logic [1:0] R_END    = 2'd1;
  localparam logic [1:0] R_EOF    = 2'd2;

  // token kinds
  localparam logic [5:0] K_IDENT    = 6'd0;
  localparam logic [5:0] K_NUMBER   = 6'd1;
  localparam logic [5:0] K_STRING   = 6'd2;
  localparam logic [5:0] K_CHAR     = 6'd3;
  localparam logic [5:0] K_LPAREN   = 6'd4;
  localparam logic [5:0] K_RPAREN   = 6'd5;
  localparam logic [5:0] K_LBRACE   = 6'd6;
  localparam logic [5:0] K_RBRACE   = 6'd7;
  localparam logic [5:0] K_SEMI     = 6'd8;
  localparam logic [5:0] K_COLON    = 6'd9;
  localparam logic [5:0] K_COMMA    = 6'd10;
  localparam logic [5:0] K_DOT      = 6'd11;
  localparam logic [5:0] K_PLUS     = 6'd12;
  localparam logic [5:0] K_PLUS_EQ  = 6'd13;
  localparam logic [5:0] K_MINUS    = 6'd14;
  localparam logic [5:0] K_STAR     = 6'd15;
  localparam logic [5:0] K_ASSIGN   = 6'd16;
  localparam logic [5:0] K_EQ_EQ    = 6'd17;
  localparam logic [5:0] K_NOT_EQ   = 6'd18;
  localparam logic [5:0] K_LT       = 6'd19;
  localparam logic [5:0] K_LE       = 6'd20;
  localparam logic [5:0] K_GT       = 6'd21;
  localparam logic [5:0] K_GE       = 6'd22;
  localparam logic [5:0] K_KW_BASE  = 6'd23;
  localparam logic [5:0] K_DIR_BASE = 6'd44;
  localparam logic [5:0] K_EOF      = 6'd54;

  localparam int NUM_KW  = 21;
  localparam int NUM_DIR = 10;
  localparam int MAX_NAME = 8;

  // names right-aligned in 64 bits, first char at the top of the used bytes
  localparam logic [63:0] KW_STR [NUM_KW] = '{
    "int", "char", "float", "double", "void", "short", "long", "signed",
    "unsigned", "if", "else", "switch", "case", "default", "while", "do",
    "for", "continue", "break", "return", "const"
  };
  localparam int KW_LEN [NUM_KW] = '{
    3, 4, 5, 6, 4, 5, 4, 6, 8, 2, 4, 6, 4, 7, 5, 2, 3, 8, 5, 6, 5
  };
  localparam logic [63:0] DIR_STR [NUM_DIR] = '{
    "include", "define", "ifdef", "ifndef", "endif", "if", "else", "elif",
    "pragma", "undef"
  };
  localparam int DIR_LEN [NUM_DIR] = '{7, 6, 5, 6, 5, 2, 4, 4, 6, 5};

  typedef struct packed {
    logic [1:0] rtype;
    logic [7:0] lex;
    logic [5:0] kind;
  } rec_t;

  // all records caused by one item
  typedef struct packed {
    logic [2:0]      cnt;
    rec_t [3:0]      recs;
  } bundle_t;

  function automatic rec_t mk_rec(logic [1:0] t, logic [7:0] b, logic [5:0] k);
    rec_t r;
    r.rtype = t;
    r.lex = b;
    r.kind = k;
    return r;
  endfunction

  function automatic logic [7:0] escape_map(logic [7:0] b);
    logic [7:0] r;
    case (b)
      "n": r = 8'd10;
      "r": r = 8'd13;
      "t": r = 8'd9;
      "0": r = 8'd0;
      "f": r = 8'd12;
      "a": r = 8'd7;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

endpackage

### sv/clx_front.sv
// front end: scanner state machine that turns one item into a record bundle
module clx_front import clx_pkg::*; #(
  parameter int NAME_BUFFER_DEPTH = NAME_BUF_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] source_byte,
  input  logic       end_of_input,
  input  logic       q_full,
  output logic       q_push,
  output bundle_t    q_data
);

  localparam int LW = $clog2(NAME_BUFFER_DEPTH + 1);
  localparam int IW = $clog2(NAME_BUFFER_DEPTH);

  mode_t                mode, mode_next;
  logic [LW-1:0]        nlen;
  logic                 novf;
  logic                 angle, angle_next;
  logic [7:0]           nbuf [NAME_BUFFER_DEPTH];
  logic                 accept;
  logic                 nstart, npush;
  logic [5:0]           kw_kind, dir_kind;
  bundle_t              bnd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (bnd.cnt != 3'd0);
  assign q_data   = bnd;

  // keyword and directive lookup, parallel compare over the name buffer
  always_comb begin
    logic m;
    kw_kind = K_IDENT;
    dir_kind = K_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      m = !novf && (nlen == LW'(KW_LEN[k]));
      for (int p = 0; p < MAX_NAME; p++) begin
        if (p < KW_LEN[k] && nbuf[p] != KW_STR[k][8*(KW_LEN[k]-1-p) +: 8]) m = 1'b0;
      end
      if (m) kw_kind = K_KW_BASE + 6'(k);
    end
    for (int k = NUM_DIR - 1; k >= 0; k--) begin
      m = !novf && (nlen == LW'(DIR_LEN[k]));
      for (int p = 0; p < MAX_NAME; p++) begin
        if (p < DIR_LEN[k] && nbuf[p] != DIR_STR[k][8*(DIR_LEN[k]-1-p) +: 8]) m = 1'b0;
      end
      if (m) dir_kind = K_DIR_BASE + 6'(k);
    end
  end

  // next mode and records for the current item
  always_comb begin
    logic redo;
    logic [7:0] b;
    b = source_byte;
    redo = 1'b0;
    mode_next = mode;
    angle_next = angle;
    nstart = 1'b0;
    npush = 1'b0;
    bnd = '0;
    if (end_of_input) begin
      unique case (mode)
        M_PLUS: begin
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_PLUS); bnd.cnt++;
        end
        M_EQ: begin
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_ASSIGN); bnd.cnt++;
        end
        M_LT: begin
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_LT); bnd.cnt++;
        end
        M_GT: begin
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_GT); bnd.cnt++;
        end
        M_NUMBER: begin
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_NUMBER); bnd.cnt++;
        end
        M_IDENT: begin
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, kw_kind); bnd.cnt++;
        end
        M_HASH, M_PATH: begin
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_IDENT); bnd.cnt++;
        end
        M_DIRECTIVE: begin
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, dir_kind); bnd.cnt++;
        end
        M_CHAR_ESC: begin
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_LEXEME, "\\", K_IDENT); bnd.cnt++;
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_CHAR); bnd.cnt++;
        end
        M_CHAR: begin
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_CHAR); bnd.cnt++;
        end
        M_STRING: begin
          bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_STRING); bnd.cnt++;
        end
        default: ;
      endcase
      bnd.recs[bnd.cnt[1:0]] = mk_rec(R_EOF, 8'd0, K_EOF); bnd.cnt++;
      mode_next = M_IDLE;
      angle_next = 1'b0;
    end else begin
      // continuation of the open token
      unique case (mode)
        M_PLUS, M_EQ, M_BANG, M_LT, M_GT: begin
          mode_next = M_IDLE;
          if (b == "=") begin
            bnd.recs[0] = mk_rec(R_END, 8'd0,
              mode == M_PLUS ? K_PLUS_EQ : mode == M_EQ ? K_EQ_EQ :
              mode == M_BANG ? K_NOT_EQ : mode == M_LT ? K_LE : K_GE);
            bnd.cnt = 3'd1;
          end else begin
            redo = 1'b1;
            if (mode != M_BANG) begin
              bnd.recs[0] = mk_rec(R_END, 8'd0,
                mode == M_PLUS ? K_PLUS : mode == M_EQ ? K_ASSIGN :
                mode == M_LT ? K_LT : K_GT);
              bnd.cnt = 3'd1;
            end
          end
        end
        M_NUMBER: begin
          if (is_num(b) || b == ".") begin
            bnd.recs[0] = mk_rec(R_LEXEME, b, K_IDENT); bnd.cnt = 3'd1;
          end else begin
            bnd.recs[0] = mk_rec(R_END, 8'd0, K_NUMBER); bnd.cnt = 3'd1;
            redo = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_letter(b) || is_num(b)) begin
            npush = 1'b1;
            bnd.recs[0] = mk_rec(R_LEXEME, b, K_IDENT); bnd.cnt = 3'd1;
          end else begin
            bnd.recs[0] = mk_rec(R_END, 8'd0, kw_kind); bnd.cnt = 3'd1;
            redo = 1'b1;
          end
        end
        M_HASH: begin
          if (b == " " || b == "\t") begin
            mode_next = M_HASH;
          end else if (is_letter(b)) begin
            nstart = 1'b1;
            bnd.recs[0] = mk_rec(R_LEXEME, b, K_IDENT); bnd.cnt = 3'd1;
            mode_next = M_DIRECTIVE;
          end else begin
            bnd.recs[0] = mk_rec(R_END, 8'd0, K_IDENT); bnd.cnt = 3'd1;
            redo = 1'b1;
          end
        end
        M_DIRECTIVE: begin
          if (is_letter(b)) begin
            npush = 1'b1;
            bnd.recs[0] = mk_rec(R_LEXEME, b, K_IDENT); bnd.cnt = 3'd1;
          end else begin
            bnd.recs[0] = mk_rec(R_END, 8'd0, dir_kind); bnd.cnt = 3'd1;
            if (dir_kind != K_DIR_BASE) begin
              redo = 1'b1;
            end else if (b == " " || b == "\t") begin
              mode_next = M_INCL;
            end else if (b == "\"" || b == "<") begin
              angle_next = (b == "<");
              mode_next = M_PATH;
            end else begin
              redo = 1'b1;
            end
          end
        end
        M_INCL: begin
          if (b == " " || b == "\t") begin
            mode_next = M_INCL;
          end else if (b == "\"" || b == "<") begin
            angle_next = (b == "<");
            mode_next = M_PATH;
          end else begin
            redo = 1'b1;
          end
        end
        M_PATH: begin
          if (b == (angle ? 8'(">") : 8'("\"")) || b == "\n") begin
            bnd.recs[0] = mk_rec(R_END, 8'd0, K_IDENT); bnd.cnt = 3'd1;
            mode_next = M_IDLE;
          end else begin
            bnd.recs[0] = mk_rec(R_LEXEME, b, K_IDENT); bnd.cnt = 3'd1;
          end
        end
        M_CHAR: begin
          if (b == "'" || b == "\n") begin
            bnd.recs[0] = mk_rec(R_END, 8'd0, K_CHAR); bnd.cnt = 3'd1;
            mode_next = M_IDLE;
          end else if (b == "\\") begin
            mode_next = M_CHAR_ESC;
          end else begin
            bnd.recs[0] = mk_rec(R_LEXEME, b, K_IDENT); bnd.cnt = 3'd1;
          end
        end
        M_CHAR_ESC: begin
          bnd.recs[0] = mk_rec(R_LEXEME, escape_map(b), K_IDENT); bnd.cnt = 3'd1;
          mode_next = M_CHAR;
        end
        M_STRING: begin
          if (b == "\"") begin
            bnd.recs[0] = mk_rec(R_END, 8'd0, K_STRING); bnd.cnt = 3'd1;
            mode_next = M_IDLE;
          end else begin
            bnd.recs[0] = mk_rec(R_LEXEME, b, K_IDENT); bnd.cnt = 3'd1;
          end
        end
        default: redo = 1'b1;
      endcase

      // byte that starts a new token
      if (redo) begin
        mode_next = M_IDLE;
        case (b)
          "(": begin bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_LPAREN); bnd.cnt++; end
          ")": begin bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_RPAREN); bnd.cnt++; end
          "{": begin bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_LBRACE); bnd.cnt++; end
          "}": begin bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_RBRACE); bnd.cnt++; end
          ";": begin bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_SEMI); bnd.cnt++; end
          ":": begin bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_COLON); bnd.cnt++; end
          ",": begin bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_COMMA); bnd.cnt++; end
          ".": begin bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_DOT); bnd.cnt++; end
          "-": begin bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_MINUS); bnd.cnt++; end
          "*": begin bnd.recs[bnd.cnt[1:0]] = mk_rec(R_END, 8'd0, K_STAR); bnd.cnt++; end
          "+": mode_next = M_PLUS;
          "=": mode_next = M_EQ;
          "!": mode_next = M_BANG;
          "<": mode_next = M_LT;
          ">": mode_next = M_GT;
          "#": mode_next = M_HASH;
          "'": mode_next = M_CHAR;
          "\"": mode_next = M_STRING;
          default: begin
            if (is_num(b)) begin
              bnd.recs[bnd.cnt[1:0]] = mk_rec(R_LEXEME, b, K_IDENT); bnd.cnt++;
              mode_next = M_NUMBER;
            end else if (is_letter(b)) begin
              nstart = 1'b1;
              bnd.recs[bnd.cnt[1:0]] = mk_rec(R_LEXEME, b, K_IDENT); bnd.cnt++;
              mode_next = M_IDENT;
            end
          end
        endcase
      end
    end
  end

  // mode and name state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      nlen <= '0;
      novf <= 1'b0;
      angle <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      angle <= angle_next;
      if (end_of_input) begin
        nlen <= '0;
        novf <= 1'b0;
      end else if (nstart) begin
        nlen <= LW'(1);
        novf <= 1'b0;
      end else if (npush) begin
        if (nlen < LW'(NAME_BUFFER_DEPTH)) nlen <= nlen + LW'(1);
        else novf <= 1'b1;
      end
    end
  end

  // name buffer, no reset
  always_ff @(posedge clk) begin
    if (accept && !end_of_input) begin
      if (nstart) nbuf[0] <= source_byte;
      else if (npush && nlen < LW'(NAME_BUFFER_DEPTH)) nbuf[nlen[IW-1:0]] <= source_byte;
    end
  end

`ifndef SYNTHESIS
  a_eof_idle: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_input |=> mode == M_IDLE && nlen == '0)
    else $error("mode not cleared after end of input");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    nlen <= LW'(NAME_BUFFER_DEPTH))
    else $error("name length past buffer depth");
  a_eof_bundle: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_input |-> q_push)
    else $error("end of input produced no records");
`endif

endmodule

### sv/clx_queue.sv
// short bundle queue between front and back
module clx_queue import clx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wdata,
  output logic    full,
  input  logic    pop,
  output logic    nonempty,
  output bundle_t rdata
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bundle_t       mem [QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full     = count == CW'(QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign rdata    = mem[rptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PW'(1);
      if (pop) rptr <= rptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !nonempty |-> !pop)
    else $error("pop from empty queue");
  a_count_ptr: assert property (@(posedge clk) disable iff (rst)
    count == '0 || count == CW'(QUEUE_DEPTH) || wptr != rptr)
    else $error("pointers disagree with count");
`endif

endmodule

### sv/clx_back.sv
// back end: walks the head bundle, one record per cycle if out_ready
module clx_back import clx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  bundle_t    head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] record_type,
  output logic [7:0] lexeme_byte,
  output logic [5:0] token_kind,
  output logic       last_of_run
);

  logic [1:0] idx;
  logic       fire;
  rec_t       cur;

  assign cur         = head.recs[idx];
  assign out_valid   = head_valid;
  assign record_type = cur.rtype;
  assign lexeme_byte = cur.lex;
  assign token_kind  = cur.kind;
  assign last_of_run = ({1'b0, idx} + 3'd1) == head.cnt;
  assign fire        = out_valid && out_ready;
  assign pop         = fire && last_of_run;

  // record index inside the bundle
  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (fire) idx <= last_of_run ? 2'd0 : idx + 2'd1;
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, idx} < head.cnt)
    else $error("record index past bundle");
  a_idle_idx: assert property (@(posedge clk) disable iff (rst) !out_valid |-> idx == 2'd0)
    else $error("index not at start while empty");
  a_last_wrap: assert property (@(posedge clk) disable iff (rst) pop |=> idx == 2'd0)
    else $error("index not reset after last record");
`endif

endmodule

### sv/c_subset_lexer_unit.sv
// c-subset lexer top level: front scanner, bundle queue, record back end
// an item's records pass through the bundle queue before the back end presents them
// throughput: one item per cycle in while the queue is not full; one record per
// cycle out while out_ready is high; the 4-entry queue absorbs bursts
// reset: synchronous rst clears scan mode, name length, queue and record index
module c_subset_lexer_unit import clx_pkg::*; #(
  parameter int NAME_BUFFER_DEPTH = NAME_BUF_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] source_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] record_type,
  output logic [7:0] lexeme_byte,
  output logic [5:0] token_kind,
  output logic       last_of_run
);

  logic    q_full, q_push, q_pop, q_nonempty;
  bundle_t q_wdata, q_rdata;

  clx_front #(.NAME_BUFFER_DEPTH(NAME_BUFFER_DEPTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .source_byte, .end_of_input,
    .q_full, .q_push, .q_data(q_wdata)
  );

  clx_queue u_queue (
    .clk, .rst, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .nonempty(q_nonempty), .rdata(q_rdata)
  );

  clx_back u_back (
    .clk, .rst, .head_valid(q_nonempty), .head(q_rdata), .pop(q_pop),
    .out_valid, .out_ready, .record_type, .lexeme_byte, .token_kind, .last_of_run
  );

endmodule
